>>> design/rse_pkg.sv
// shared types and constants for the raster rgb24 stream encoder
// no dependencies
`timescale 1ns / 1ps

package rse_pkg;

    localparam int          DATA_W        = 8;
    localparam int          DIM_W         = 16;
    localparam int          LEN_W         = 32;
    localparam int          MIX_W         = 16;
    localparam int          QUEUE_DEPTH   = 2;
    localparam int          POS_W         = 6;

    localparam logic [31:0] SR_MAGIC      = 32'h59a6_6a95;
    localparam logic [31:0] SR_DEPTH      = 32'd24;
    localparam logic [31:0] SR_TYPE       = 32'd1;

    localparam logic        CFG_WIDTH     = 1'b0;
    localparam logic        CFG_HEIGHT    = 1'b1;

    localparam logic [POS_W-1:0] POS_FIRST = 6'd0;
    localparam logic [POS_W-1:0] POS_BLUE  = 6'd32;
    localparam logic [POS_W-1:0] POS_GREEN = 6'd33;
    localparam logic [POS_W-1:0] POS_RED   = 6'd34;
    localparam logic [POS_W-1:0] POS_PAD   = 6'd35;

    // one classified pixel, as handed from front to back
    typedef struct packed {
        logic              err;
        logic              hdr;
        logic              pad;
        logic [MIX_W-1:0]  mix_b;
        logic [MIX_W-1:0]  mix_g;
        logic [MIX_W-1:0]  mix_r;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [LEN_W-1:0]  length;
    } t_entry;

endpackage

>>> design/rse_front.sv
// front end: geometry registers, pixel accept, classification and compositing products
// depends on rse_pkg
`timescale 1ns / 1ps

module rse_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_addr,
    input  logic [rse_pkg::DIM_W-1:0]     i_cfg_wdata,
    input  logic                          i_valid,
    input  logic [4*rse_pkg::DATA_W-1:0]  i_pixel,
    input  logic                          i_full,
    output logic                          o_ready,
    output logic                          o_push,
    output rse_pkg::t_entry               o_entry
);
    import rse_pkg::*;

    logic [DIM_W-1:0]   r_width, r_height, n_width, n_height;
    logic [DIM_W-1:0]   r_col, r_row, n_col, n_row;
    logic [DIM_W+1:0]   padded;
    logic [DIM_W*2+1:0] length;
    logic               err, row_end, img_end, push;
    logic [DATA_W-1:0]  k, kc;
    logic [MIX_W-1:0]   white;

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_WIDTH:  n_width  = i_cfg_wdata;
                CFG_HEIGHT: n_height = i_cfg_wdata;
                default:    ;
            endcase
        end
    end

    // padded row bytes: 3w rounded up to even
    assign padded  = {1'b0, r_width, 1'b0} + {2'b00, r_width} + {{(DIM_W+1){1'b0}}, r_width[0]};
    assign length  = padded * r_height;
    assign err     = (r_width == '0) || (r_height == '0) || (length[DIM_W*2+1:LEN_W] != '0);
    assign row_end = ({1'b0, r_col} + 1'b1) >= {1'b0, r_width};
    assign img_end = ({1'b0, r_row} + 1'b1) >= {1'b0, r_height};

    assign o_ready = !i_full;
    assign push    = i_valid && !i_full;
    assign o_push  = push;

    // composite over white: v*a + 255*(255-a) + 127
    assign k     = i_pixel[4*DATA_W-1:3*DATA_W];
    assign kc    = ~k;
    assign white = {kc, 8'h00} - {8'h00, kc} + MIX_W'(127);

    always_comb begin
        o_entry.err    = err;
        o_entry.hdr    = (r_col == '0) && (r_row == '0);
        o_entry.pad    = row_end && r_width[0];
        o_entry.mix_r  = i_pixel[DATA_W-1:0] * k + white;
        o_entry.mix_g  = i_pixel[2*DATA_W-1:DATA_W] * k + white;
        o_entry.mix_b  = i_pixel[3*DATA_W-1:2*DATA_W] * k + white;
        o_entry.width  = r_width;
        o_entry.height = r_height;
        o_entry.length = length[LEN_W-1:0];
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (push && !err) begin
            if (row_end) begin
                n_col = '0;
                n_row = img_end ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end

endmodule

>>> design/rse_queue.sv
// small queue of classified pixels between front and back
// depends on rse_pkg
`timescale 1ns / 1ps

module rse_queue #(
    parameter int DEPTH = rse_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rse_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output rse_pkg::t_entry o_entry
);
    import rse_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = r_cnt == CNT_W'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_entry = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> design/rse_back.sv
// back end: walks header, pixel and pad bytes of the queue head into the output register
// depends on rse_pkg
`timescale 1ns / 1ps

module rse_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  rse_pkg::t_entry             i_entry,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rse_pkg::DATA_W-1:0]  o_data,
    output logic                        o_last,
    output logic                        o_err
);
    import rse_pkg::*;

    logic [POS_W-1:0]  r_pos, n_pos, pos;
    logic              r_started, n_started;
    logic              r_valid, n_valid, r_last, n_last, r_err, n_err;
    logic [DATA_W-1:0] r_data, n_data, byte_sel;
    logic              load, last;
    logic [31:0]       word;
    logic [MIX_W-1:0]  mix;
    logic [MIX_W:0]    quot;

    assign load = i_valid && (!r_valid || i_ready);
    assign pos  = r_started ? r_pos : (i_entry.hdr ? POS_FIRST : POS_BLUE);
    assign last = i_entry.err || (pos == POS_PAD) || (pos == POS_RED && !i_entry.pad);

    always_comb begin
        case (pos[4:2])
            3'd0:    word = SR_MAGIC;
            3'd1:    word = {16'h0000, i_entry.width};
            3'd2:    word = {16'h0000, i_entry.height};
            3'd3:    word = SR_DEPTH;
            3'd4:    word = i_entry.length;
            3'd5:    word = SR_TYPE;
            default: word = '0;
        endcase
    end

    always_comb begin
        case (pos)
            POS_BLUE:  mix = i_entry.mix_b;
            POS_GREEN: mix = i_entry.mix_g;
            default:   mix = i_entry.mix_r;
        endcase
    end

    // exact divide by 255 for values below 65535
    assign quot = ({1'b0, mix} + 1'b1 + {9'h000, mix[MIX_W-1:8]}) >> 8;

    always_comb begin
        if (i_entry.err) begin
            byte_sel = '0;
        end else if (!pos[5]) begin
            case (pos[1:0])
                2'd0:    byte_sel = word[31:24];
                2'd1:    byte_sel = word[23:16];
                2'd2:    byte_sel = word[15:8];
                default: byte_sel = word[7:0];
            endcase
        end else if (pos == POS_PAD) begin
            byte_sel = '0;
        end else begin
            byte_sel = quot[DATA_W-1:0];
        end
    end

    always_comb begin
        n_valid   = r_valid;
        n_data    = r_data;
        n_last    = r_last;
        n_err     = r_err;
        n_pos     = r_pos;
        n_started = r_started;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        if (load) begin
            n_valid   = 1'b1;
            n_data    = byte_sel;
            n_last    = last;
            n_err     = i_entry.err;
            n_pos     = pos + 1'b1;
            n_started = !last;
        end
    end

    assign o_pop   = load && last;
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;
    assign o_err   = r_err;

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_last <= n_last;
        r_err  <= n_err;
        r_pos  <= n_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_started <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_started <= n_started;
        end
    end

endmodule

>>> design/raster_rgb24_stream_encoder.sv
// top level of the 24-bit raster image stream encoder
// depends on rse_pkg, rse_front, rse_queue, rse_back
//
// channel    direction  tdata                                    side band
// s_axis     in         red[7:0] green[15:8] blue[23:16] a[31:24] -
// m_axis     out        out_byte[7:0]                            tlast last_of_run, tuser size_error
// cfg        in         wdata 16 bits, addr 0 width, 1 height    write enable, no wait
//
// one output byte per cycle while output ready and a pixel queued: 3 per pixel, 4 at the end
// of an odd-width row, 32 more for an image's first pixel; a rejected geometry gives one transfer
// the back end's byte sequencer sets the rate, the front accepts while the queue has room
// synchronous active-low reset, no clearing pass; an output stall only fills the queue
`timescale 1ns / 1ps

module raster_rgb24_stream_encoder #(
    parameter int QUEUE_DEPTH = rse_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_addr,
    input  logic [rse_pkg::DIM_W-1:0]     i_cfg_wdata,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [4*rse_pkg::DATA_W-1:0]  i_s_axis_tdata,  // red, green, blue, alpha
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [rse_pkg::DATA_W-1:0]    o_m_axis_tdata,  // out_byte
    output logic                          o_m_axis_tlast,
    output logic                          o_m_axis_tuser   // size_error
);
    import rse_pkg::*;

    t_entry front_entry, head_entry;
    logic   push, pop, full, head_valid;

    rse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .i_pixel     (i_s_axis_tdata),
        .i_full      (full),
        .o_ready     (o_s_axis_tready),
        .o_push      (push),
        .o_entry     (front_entry)
    );

    rse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_entry (head_entry)
    );

    rse_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_entry (head_entry),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast),
        .o_err   (o_m_axis_tuser)
    );

endmodule

>>> design/rse_checker.sv
// port-level checks for the raster rgb24 stream encoder, bound to the top level
// depends on rse_pkg and raster_rgb24_stream_encoder
`timescale 1ns / 1ps

module rse_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [rse_pkg::DATA_W-1:0]  o_m_axis_tdata,
    input logic                        o_m_axis_tlast,
    input logic                        o_m_axis_tuser
);
    import rse_pkg::*;

    // an error transfer closes its run on its own
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> o_m_axis_tlast)
        else $error("error transfer without tlast");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("error transfer carries a byte");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)
         && $stable(o_m_axis_tuser)))
        else $error("stalled output changed");

endmodule

bind raster_rgb24_stream_encoder rse_checker u_rse_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

>>> sim/rse_stream_checker.sv
// predicts and checks the byte stream of the raster rgb24 stream encoder
// watches the pixel, byte and register channels; depends on rse_pkg
`timescale 1ns / 1ps

module rse_stream_checker
    import rse_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_addr,
    input  logic [DIM_W-1:0]     i_cfg_wdata,
    input  logic                 i_pix_valid,
    input  logic                 i_pix_ready,
    input  logic [4*DATA_W-1:0]  i_pix_data,   // red, green, blue, alpha
    input  logic                 i_byte_valid,
    input  logic                 i_byte_ready,
    input  logic [DATA_W-1:0]    i_byte_data,  // out_byte
    input  logic                 i_byte_last,
    input  logic                 i_byte_err,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              last;
        logic              err;
    } t_file_byte;

    t_file_byte       file_bytes_due[$];
    t_file_byte       want;
    logic [DIM_W-1:0] geo_width;
    logic [DIM_W-1:0] geo_height;
    logic [DIM_W-1:0] col_pos;
    logic [DIM_W-1:0] row_pos;
    int               fails = 0;

    // channel composited over white, rounded to nearest
    function automatic logic [DATA_W-1:0] over_white(logic [7:0] c, logic [7:0] k);
        int v;
        v = (int'(c) * int'(k) + 255 * (255 - int'(k)) + 127) / 255;
        return v[DATA_W-1:0];
    endfunction

    task automatic encode_pixel(input logic [4*DATA_W-1:0] px);
        longint unsigned line_len;
        longint unsigned image_len;
        logic [31:0]     hdr [8];
        t_file_byte      run[$];
        line_len  = (64'(geo_width) * 3 + 1) & ~64'd1;
        image_len = line_len * 64'(geo_height);
        if (geo_width == 0 || geo_height == 0 || image_len > 64'hffff_ffff) begin
            file_bytes_due.push_back('{data: '0, last: 1'b1, err: 1'b1});
            return;
        end
        if (col_pos == 0 && row_pos == 0) begin
            hdr = '{SR_MAGIC, {16'd0, geo_width}, {16'd0, geo_height}, SR_DEPTH,
                    image_len[31:0], SR_TYPE, 32'd0, 32'd0};
            foreach (hdr[i])
                for (int b = 3; b >= 0; b--)
                    run.push_back('{data: hdr[i][8*b +: 8], last: 1'b0, err: 1'b0});
        end
        // written blue, green, red
        run.push_back('{data: over_white(px[23:16], px[31:24]), last: 1'b0, err: 1'b0});
        run.push_back('{data: over_white(px[15:8], px[31:24]), last: 1'b0, err: 1'b0});
        run.push_back('{data: over_white(px[7:0], px[31:24]), last: 1'b0, err: 1'b0});
        if (int'(col_pos) + 1 >= int'(geo_width)) begin
            if (geo_width[0])
                run.push_back('{data: '0, last: 1'b0, err: 1'b0});
            col_pos = '0;
            if (int'(row_pos) + 1 >= int'(geo_height))
                row_pos = '0;
            else
                row_pos = row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
        run[run.size()-1].last = 1'b1;
        foreach (run[i])
            file_bytes_due.push_back(run[i]);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            geo_width  = DIM_W'(1);
            geo_height = DIM_W'(1);
            col_pos    = '0;
            row_pos    = '0;
            file_bytes_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_WIDTH)
                    geo_width = i_cfg_wdata;
                else
                    geo_height = i_cfg_wdata;
            end
            if (i_pix_valid && i_pix_ready)
                encode_pixel(i_pix_data);
            if (i_byte_valid && i_byte_ready) begin
                if (file_bytes_due.size() == 0) begin
                    $error("unexpected transfer: out_byte %0h", i_byte_data);
                    fails++;
                end else begin
                    want = file_bytes_due.pop_front();
                    if (i_byte_data !== want.data) begin
                        $error("out_byte: expected %0h, actual %0h", want.data, i_byte_data);
                        fails++;
                    end
                    if (i_byte_last !== want.last) begin
                        $error("last_of_run: expected %0b, actual %0b", want.last, i_byte_last);
                        fails++;
                    end
                    if (i_byte_err !== want.err) begin
                        $error("size_error: expected %0b, actual %0b", want.err, i_byte_err);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= file_bytes_due.size();
        o_fail_count <= fails;
    end

endmodule

>>> sim/raster_rgb24_stream_encoder_test.sv
// testbench top for the raster rgb24 stream encoder: clock, reset, pixel and
// register stimulus, output back-pressure and verdict; uses rse_stream_checker
`timescale 1ns / 1ps

module raster_rgb24_stream_encoder_test;
    import rse_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_we        = 1'b0;
    logic                 i_cfg_addr      = CFG_WIDTH;
    logic [DIM_W-1:0]     i_cfg_wdata     = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [4*DATA_W-1:0]  i_s_axis_tdata  = '0;  // red, green, blue, alpha
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [DATA_W-1:0]    o_m_axis_tdata;         // out_byte
    logic                 o_m_axis_tlast;
    logic                 o_m_axis_tuser;         // size_error

    int fail_count;
    int bytes_due;
    int pixels_sent = 0;
    int burst_left  = 0;

    always #5 i_clk = ~i_clk;

    raster_rgb24_stream_encoder uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    rse_stream_checker byte_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_pix_valid  (i_s_axis_tvalid),
        .i_pix_ready  (o_s_axis_tready),
        .i_pix_data   (i_s_axis_tdata),
        .i_byte_valid (o_m_axis_tvalid),
        .i_byte_ready (i_m_axis_tready),
        .i_byte_data  (o_m_axis_tdata),
        .i_byte_last  (o_m_axis_tlast),
        .i_byte_err   (o_m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (bytes_due)
    );

    task automatic send_pixel(input logic [7:0] r, g, b, a);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {a, b, g, r};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pixels_sent++;
    endtask

    task automatic send_random_pixel();
        logic [7:0] a;
        case ($urandom_range(0, 3))
            0:       a = 8'd0;
            1:       a = 8'd255;
            default: a = 8'($urandom_range(0, 255));
        endcase
        send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), a);
    endtask

    // drops input valid, waits until all expected bytes are out, then adds a margin
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (bytes_due != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [DIM_W-1:0] w, h);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_WIDTH;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_HEIGHT;
        i_cfg_wdata <= h;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // a 1x1 image ends any image in progress and wraps the counters
    task automatic restart_image();
        set_geometry(16'd1, 16'd1);
        send_random_pixel();
    endtask

    initial begin
        int w, h;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_geometry(16'd1, 16'd1);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd128, 8'd128);
        send_pixel(8'd1, 8'd2, 8'd3, 8'd1);
        set_geometry(16'd4, 16'd2);
        repeat (8) send_random_pixel();
        // length overflow, just past the limit, zero width, zero height
        set_geometry(16'hffff, 16'hffff);
        send_random_pixel();
        set_geometry(16'd21846, 16'hffff);
        send_random_pixel();
        set_geometry(16'd0, 16'd5);
        send_random_pixel();
        set_geometry(16'd7, 16'd0);
        send_random_pixel();
        // largest length that still fits
        set_geometry(16'd21845, 16'hffff);
        repeat (2) send_random_pixel();
        set_geometry(16'hffff, 16'd1);
        send_random_pixel();
        // width shrunk below the column mid-image
        set_geometry(16'd2, 16'd3);
        send_random_pixel();
        restart_image();

        while (pixels_sent < 370) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: begin
                    if ($urandom_range(0, 4) != 0)
                        w = $urandom_range(1, 7);
                    else
                        w = $urandom_range(8, 48);
                    h = (w > 8) ? $urandom_range(1, 2) : $urandom_range(1, 4);
                    set_geometry(w[15:0], h[15:0]);
                    repeat (w * h * $urandom_range(1, 2)) send_random_pixel();
                end
                7: begin
                    case ($urandom_range(0, 3))
                        0: begin
                            w = 0;
                            h = $urandom_range(0, 65535);
                        end
                        1: begin
                            w = $urandom_range(0, 65535);
                            h = 0;
                        end
                        default: begin
                            w = $urandom_range(1, 65535);
                            h = $urandom_range(16384, 65535);
                        end
                    endcase
                    set_geometry(w[15:0], h[15:0]);
                    repeat ($urandom_range(1, 3)) send_random_pixel();
                    restart_image();
                end
                default: begin
                    w = $urandom_range(2, 7);
                    h = $urandom_range(1, 4);
                    set_geometry(w[15:0], h[15:0]);
                    repeat ($urandom_range(1, w * h - 1)) send_random_pixel();
                    set_geometry(16'($urandom_range(1, 5)), 16'($urandom_range(1, 3)));
                    repeat ($urandom_range(1, 3)) send_random_pixel();
                    restart_image();
                end
            endcase
        end

        wait_idle();
        if (fail_count == 0 && bytes_due == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // output back-pressure; one long hold-off once the input is busy
    initial begin
        int  mode;
        int  span;
        int  tick;
        int  in_count;
        bit  held;
        tick     = 0;
        in_count = 0;
        held     = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(posedge i_clk);
                if (i_s_axis_tvalid && o_s_axis_tready)
                    in_count++;
                tick++;
                if (!held && in_count >= 60 && i_s_axis_tvalid) begin
                    held = 1'b1;
                    repeat (400) begin
                        i_m_axis_tready <= 1'b0;
                        @(posedge i_clk);
                    end
                end
                case (mode)
                    0:       i_m_axis_tready <= 1'b1;
                    1:       i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2:       i_m_axis_tready <= (tick % 3 == 0);
                    default: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // watchdog on cycles without any transfer, register write or reset
    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (i_s_axis_tvalid && o_s_axis_tready)
                    || (o_m_axis_tvalid && i_m_axis_tready))
                idle = 0;
            else
                idle++;
        end
        $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
design/rse_pkg.sv
design/rse_front.sv
design/rse_queue.sv
design/rse_back.sv
design/raster_rgb24_stream_encoder.sv
design/rse_checker.sv
sim/rse_stream_checker.sv
sim/raster_rgb24_stream_encoder_test.sv
